FILE: rtl/core/pafmt_pkg.sv
// pafmt_pkg: shared types, character codes and helper functions of the pose
// ascii frame formatter. No dependencies.
package pafmt_pkg;

  localparam int NUM_VALUES = 6;
  localparam int VAL_W      = 25;
  localparam int MAG_W      = 24;
  localparam int DIGITS     = 7;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int LANE_W     = 3;
  localparam int POS_W      = 4;
  localparam int IDX_W      = 6;
  localparam int BIT_W      = 5;

  localparam logic [MAG_W-1:0] MAG_MAX    = 24'd9999999;
  localparam logic [BIT_W-1:0] LAST_BIT   = 5'(MAG_W - 1);
  localparam logic [LANE_W-1:0] LAST_LANE = 3'(NUM_VALUES - 1);
  localparam logic [POS_W-1:0] LAST_POS   = 4'd8;

  // frame positions
  localparam logic [IDX_W-1:0] IDX_PAD   = 6'd54;
  localparam logic [IDX_W-1:0] IDX_CKS_H = 6'd60;
  localparam logic [IDX_W-1:0] IDX_CKS_T = 6'd61;
  localparam logic [IDX_W-1:0] IDX_CKS_O = 6'd62;
  localparam logic [IDX_W-1:0] IDX_LAST  = 6'd63;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;

  // six pad spaces, seeded into the checksum at load (6 * 32 mod 256)
  localparam logic [7:0] SUM_SEED = 8'(6 * 32);
  // per value: '.' plus seven '0' offsets, mod 256
  localparam logic [7:0] LANE_CONST = 8'(46 + 7 * 48);

  typedef logic [NUM_VALUES-1:0][VAL_W-1:0] pose_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic sum_en;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic lane_last;
    logic byte_last;
  } sts_t;

  // add-3 step of the shift-and-add binary to bcd conversion
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int k = 0; k < DIGITS; k++) begin
      if (r[4*k +: 4] >= 4'd5) begin
        r[4*k +: 4] = r[4*k +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] to_ascii(input logic [3:0] d);
    return CH_ZERO + {4'd0, d};
  endfunction

endpackage

FILE: rtl/core/pafmt_ctrl.sv
// pafmt_ctrl: sequencer of the pose ascii frame formatter (load, convert,
// checksum, emit). Depends on pafmt_pkg.
module pafmt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            pose_valid,
  output logic            pose_ready,
  output logic            frame_valid,
  input  logic            frame_ready,
  input  pafmt_pkg::sts_t sts,
  output pafmt_pkg::cmd_t cmd
);
  import pafmt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [BIT_W-1:0] bit_cnt;

  assign pose_ready  = (state == S_IDLE);
  assign frame_valid = (state == S_EMIT);

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.shift   = 1'b0;
    cmd.sum_en  = 1'b0;
    cmd.advance = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (pose_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        if (bit_cnt == LAST_BIT) state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        if (sts.lane_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (frame_ready) begin
          cmd.advance = 1'b1;
          if (sts.byte_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_cnt <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) bit_cnt <= '0;
      else if (cmd.shift) bit_cnt <= bit_cnt + 5'd1;
    end
  end

  cv_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(pose_ready && frame_valid))
    else $error("pose ready while frame bytes pending");

  cv_conv_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV && bit_cnt != LAST_BIT) |=> (state == S_CONV))
    else $error("conversion left early");

  cv_load_conv: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_CONV && bit_cnt == '0))
    else $error("load did not start conversion");

endmodule

FILE: rtl/core/pafmt_dp.sv
// pafmt_dp: datapath of the pose ascii frame formatter: saturation, six
// bcd conversion lanes, checksum and byte selection. Depends on pafmt_pkg.
module pafmt_dp (
  input  logic             clk,
  input  logic             rst,
  input  pafmt_pkg::pose_t pose,
  input  pafmt_pkg::cmd_t  cmd,
  output pafmt_pkg::sts_t  sts,
  output logic [7:0]       frame_byte,
  output logic             frame_last,
  output logic             clipped
);
  import pafmt_pkg::*;

  logic [NUM_VALUES-1:0]            neg;
  logic [NUM_VALUES-1:0][MAG_W-1:0] sh;
  logic [NUM_VALUES-1:0][BCD_W-1:0] bcd;
  logic                             clip;
  logic [7:0]                       sum;
  logic [LANE_W-1:0]                lane;
  logic [POS_W-1:0]                 pos;
  logic [IDX_W-1:0]                 byte_index;

  // saturated magnitudes at load
  logic [NUM_VALUES-1:0]            neg_in;
  logic [NUM_VALUES-1:0][MAG_W-1:0] mag_in;
  logic [NUM_VALUES-1:0]            sat_in;

  always_comb begin
    logic [VAL_W-1:0] m;
    for (int l = 0; l < NUM_VALUES; l++) begin
      neg_in[l] = pose[l][VAL_W-1];
      m = neg_in[l] ? (~pose[l] + 25'd1) : pose[l];
      sat_in[l] = (m > {1'b0, MAG_MAX});
      mag_in[l] = sat_in[l] ? MAG_MAX : m[MAG_W-1:0];
    end
  end

  // add-3 adjusted digits ahead of each shift
  logic [NUM_VALUES-1:0][BCD_W-1:0] bcd_adj;
  always_comb begin
    for (int l = 0; l < NUM_VALUES; l++) begin
      bcd_adj[l] = bcd_adjust(bcd[l]);
    end
  end

  // lane picked by the lane counter
  logic [BCD_W-1:0] sel_bcd;
  logic             sel_neg;
  always_comb begin
    sel_bcd = '0;
    sel_neg = 1'b0;
    for (int l = 0; l < NUM_VALUES; l++) begin
      if (lane == 3'(l)) begin
        sel_bcd = bcd[l];
        sel_neg = neg[l];
      end
    end
  end

  logic [7:0] sign_ch;
  logic [5:0] digit_sum;
  assign sign_ch = sel_neg ? CH_MINUS : CH_PLUS;

  always_comb begin
    digit_sum = '0;
    for (int k = 0; k < DIGITS; k++) begin
      digit_sum = digit_sum + {2'd0, sel_bcd[4*k +: 4]};
    end
  end

  // checksum in decimal; t = r / 10 by reciprocal, exact for r below 100
  logic [1:0]  cks_h;
  logic [7:0]  cks_r;
  logic [14:0] cks_mul;
  logic [3:0]  cks_t;
  logic [3:0]  cks_o;
  always_comb begin
    if (sum >= 8'd200) cks_h = 2'd2;
    else if (sum >= 8'd100) cks_h = 2'd1;
    else cks_h = 2'd0;
    cks_r   = sum - ({6'd0, cks_h} * 8'd100);
    cks_mul = {8'd0, cks_r[6:0]} * 15'd205;
    cks_t   = cks_mul[14:11];
    cks_o   = 4'(cks_r - ({4'd0, cks_t} * 8'd10));
  end

  logic [7:0] value_ch;
  always_comb begin
    unique case (pos)
      4'd0:    value_ch = sign_ch;
      4'd1:    value_ch = to_ascii(sel_bcd[27:24]);
      4'd2:    value_ch = to_ascii(sel_bcd[23:20]);
      4'd3:    value_ch = to_ascii(sel_bcd[19:16]);
      4'd4:    value_ch = CH_DOT;
      4'd5:    value_ch = to_ascii(sel_bcd[15:12]);
      4'd6:    value_ch = to_ascii(sel_bcd[11:8]);
      4'd7:    value_ch = to_ascii(sel_bcd[7:4]);
      4'd8:    value_ch = to_ascii(sel_bcd[3:0]);
      default: value_ch = CH_SPACE;
    endcase
  end

  always_comb begin
    priority if (byte_index < IDX_PAD) frame_byte = value_ch;
    else if (byte_index < IDX_CKS_H)   frame_byte = CH_SPACE;
    else if (byte_index == IDX_CKS_H)  frame_byte = to_ascii({2'd0, cks_h});
    else if (byte_index == IDX_CKS_T)  frame_byte = to_ascii(cks_t);
    else if (byte_index == IDX_CKS_O)  frame_byte = to_ascii(cks_o);
    else                               frame_byte = CH_HASH;
  end

  assign frame_last    = (byte_index == IDX_LAST);
  assign clipped       = clip;
  assign sts.lane_last = (lane == LAST_LANE);
  assign sts.byte_last = frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      neg        <= '0;
      sh         <= '0;
      bcd        <= '0;
      clip       <= 1'b0;
      sum        <= '0;
      lane       <= '0;
      pos        <= '0;
      byte_index <= '0;
    end else begin
      if (cmd.load) begin
        neg        <= neg_in;
        sh         <= mag_in;
        bcd        <= '0;
        clip       <= |sat_in;
        sum        <= SUM_SEED;
        lane       <= '0;
        pos        <= '0;
        byte_index <= '0;
      end
      if (cmd.shift) begin
        for (int l = 0; l < NUM_VALUES; l++) begin
          bcd[l] <= {bcd_adj[l][BCD_W-2:0], sh[l][MAG_W-1]};
          sh[l]  <= {sh[l][MAG_W-2:0], 1'b0};
        end
      end
      if (cmd.sum_en) begin
        sum  <= sum + sign_ch + LANE_CONST + {2'd0, digit_sum};
        lane <= sts.lane_last ? '0 : lane + 3'd1;
      end
      if (cmd.advance) begin
        byte_index <= byte_index + 6'd1;
        if (pos == LAST_POS) begin
          pos  <= '0;
          lane <= lane + 3'd1;
        end else begin
          pos <= pos + 4'd1;
        end
      end
    end
  end

  dp_lane_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.advance && byte_index < IDX_PAD) |-> (lane <= LAST_LANE && pos <= LAST_POS))
    else $error("lane or position counter out of step with byte index");

  dp_wrap: assert property (@(posedge clk) disable iff (rst)
    (cmd.advance && frame_last) |=> (byte_index == '0))
    else $error("byte index did not wrap after the last byte");

  dp_digits_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.sum_en |-> (sel_bcd[27:24] <= 4'd9 && sel_bcd[3:0] <= 4'd9))
    else $error("bcd digit out of range after conversion");

endmodule

FILE: rtl/core/pose_ascii_frame_formatter_unit.sv
// pose_ascii_frame_formatter_unit: top level of the pose ascii frame formatter.
// Depends on pafmt_pkg, pafmt_ctrl and pafmt_dp.
//
// Usage: one pose beat (six 25-bit signed values in units of 1e-4) is taken
// on the pose channel when pose_valid and pose_ready are high together. The
// block answers with 64 frame beats, one ASCII byte each: six fields of
// nine characters (sign, three integer digits, '.', four fraction digits),
// six spaces, the 8-bit byte sum of the first 60 bytes as three decimal
// digits, and '#'. frame_last marks the 64th beat; clipped is high on every
// beat of a frame in which some magnitude above 999.9999 was saturated.
// After the pose beat, a bit-serial bcd conversion (all six values in
// parallel lanes) is followed by a checksum pass, one value per cycle,
// before the first frame beat is offered. A new pose is accepted only
// after the accept, convert, checksum and 64 byte steps have all passed;
// pose_ready is high only while no frame is pending.
// A stalled receiver holds the current byte and freezes the byte counter.
// Reset (synchronous) returns to idle with no frame pending.
module pose_ascii_frame_formatter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        pose_valid,
  output logic        pose_ready,
  input  logic [24:0] pos_x,
  input  logic [24:0] pos_y,
  input  logic [24:0] pos_z,
  input  logic [24:0] rot_roll,
  input  logic [24:0] rot_pitch,
  input  logic [24:0] rot_yaw,
  output logic        frame_valid,
  input  logic        frame_ready,
  output logic [7:0]  frame_byte,
  output logic        frame_last,
  output logic        clipped
);
  import pafmt_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  pose_t pose;

  assign pose = {rot_yaw, rot_pitch, rot_roll, pos_z, pos_y, pos_x};

  pafmt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pose_valid  (pose_valid),
    .pose_ready  (pose_ready),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  pafmt_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .pose       (pose),
    .cmd        (cmd),
    .sts        (sts),
    .frame_byte (frame_byte),
    .frame_last (frame_last),
    .clipped    (clipped)
  );

  top_end_of_frame: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && frame_ready && frame_last) |=> !frame_valid)
    else $error("frame beats continued past the last byte");

  top_hash_last: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && frame_last) |-> (frame_byte == CH_HASH))
    else $error("last frame byte is not the terminator");

  top_no_early_byte: assert property (@(posedge clk) disable iff (rst)
    (pose_valid && pose_ready) |=> !frame_valid)
    else $error("frame beat offered before conversion");

endmodule

FILE: sim/pose_ascii_frame_formatter_unit_tb.sv
// pose_ascii_frame_formatter_unit_tb: self-checking bench for the pose ascii frame formatter.
// Depends on pafmt_pkg and pose_ascii_frame_formatter_unit; pose beats go in, frame beats are
// compared one by one against frames predicted locally from each accepted pose.
module pose_ascii_frame_formatter_unit_tb;
  import pafmt_pkg::*;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       clip;
  } frame_beat_t;

  localparam int FRAME_BYTES   = 64;
  localparam int PAD_START     = 54;
  localparam int CKS_START     = 60;
  localparam int MAG_LIMIT     = 9999999;
  localparam int RANDOM_POSES  = 280;
  localparam int PHASE_POSES   = 35;
  localparam int HOLD_AT_POSE  = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 120;
  localparam int POSE_CAP      = 320;
  localparam int BEAT_CAP      = POSE_CAP * FRAME_BYTES;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pose_valid = 1'b0;
  logic        pose_ready;
  logic [24:0] pos_x = '0;
  logic [24:0] pos_y = '0;
  logic [24:0] pos_z = '0;
  logic [24:0] rot_roll = '0;
  logic [24:0] rot_pitch = '0;
  logic [24:0] rot_yaw = '0;
  logic        frame_valid;
  logic        frame_ready = 1'b0;
  logic [7:0]  frame_byte;
  logic        frame_last;
  logic        clipped;

  pose_t       pending_poses [POSE_CAP];
  frame_beat_t expected_beats [BEAT_CAP];
  int          pend_wr = 0;
  int          pend_rd = 0;
  int          exp_wr = 0;
  int          exp_rd = 0;
  pose_t       next_pose;
  frame_beat_t got_beat;
  frame_beat_t want_beat;
  bit          pose_beat = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          n_accepted = 0;
  int          n_errors = 0;

  pose_ascii_frame_formatter_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .pose_valid (pose_valid),
    .pose_ready (pose_ready),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .rot_roll   (rot_roll),
    .rot_pitch  (rot_pitch),
    .rot_yaw    (rot_yaw),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready),
    .frame_byte (frame_byte),
    .frame_last (frame_last),
    .clipped    (clipped)
  );

  always #6 clk = ~clk;

  function automatic idle_phase_t idle_phase();
    return idle_phase_t'((n_accepted / PHASE_POSES) % 4);
  endfunction

  function automatic int send_idle_pct();
    case (idle_phase())
      PH_SEND_IDLE: return 61;
      PH_BOTH:      return 14;
      default:      return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_phase())
      PH_RECV_STALL: return 61;
      PH_BOTH:       return 14;
      default:       return 0;
    endcase
  endfunction

  // expected 64-byte frame for one pose, appended to the expectation store
  task automatic push_frame(input pose_t p);
    logic [7:0]  ch [FRAME_BYTES];
    int          s;
    int          mag;
    int          ip;
    int          fp;
    int          sum;
    bit          clip;
    frame_beat_t b;
    clip = 1'b0;
    sum  = 0;
    for (int i = 0; i < NUM_VALUES; i++) begin
      s   = int'($signed(p[i]));
      mag = (s < 0) ? -s : s;
      ch[i*9] = (s < 0) ? CH_MINUS : CH_PLUS;
      if (mag > MAG_LIMIT) begin
        mag  = MAG_LIMIT;
        clip = 1'b1;
      end
      ip = mag / 10000;
      fp = mag % 10000;
      ch[i*9+1] = CH_ZERO + 8'((ip / 100) % 10);
      ch[i*9+2] = CH_ZERO + 8'((ip / 10) % 10);
      ch[i*9+3] = CH_ZERO + 8'(ip % 10);
      ch[i*9+4] = CH_DOT;
      ch[i*9+5] = CH_ZERO + 8'((fp / 1000) % 10);
      ch[i*9+6] = CH_ZERO + 8'((fp / 100) % 10);
      ch[i*9+7] = CH_ZERO + 8'((fp / 10) % 10);
      ch[i*9+8] = CH_ZERO + 8'(fp % 10);
    end
    for (int i = PAD_START; i < CKS_START; i++) ch[i] = CH_SPACE;
    for (int i = 0; i < CKS_START; i++) sum += ch[i];
    sum = sum % 256;
    ch[CKS_START]   = CH_ZERO + 8'(sum / 100);
    ch[CKS_START+1] = CH_ZERO + 8'((sum / 10) % 10);
    ch[CKS_START+2] = CH_ZERO + 8'(sum % 10);
    ch[CKS_START+3] = CH_HASH;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      b.ch   = ch[i];
      b.last = (i == FRAME_BYTES - 1);
      b.clip = clip;
      expected_beats[exp_wr] = b;
      exp_wr = exp_wr + 1;
    end
  endtask

  task automatic add_pose(input int v0, input int v1, input int v2,
                          input int v3, input int v4, input int v5);
    pose_t p;
    p[0] = 25'(v0);
    p[1] = 25'(v1);
    p[2] = 25'(v2);
    p[3] = 25'(v3);
    p[4] = 25'(v4);
    p[5] = 25'(v5);
    pending_poses[pend_wr] = p;
    pend_wr = pend_wr + 1;
  endtask

  // mostly in-range values, with boundary, small and full-width noise mixed in
  function automatic logic [24:0] rand_value();
    int k;
    int m;
    k = $urandom_range(0, 9);
    case (k)
      6:       m = $urandom_range(0, 20000);
      7:       return 25'($urandom);
      8:       m = $urandom_range(MAG_LIMIT - 10, MAG_LIMIT + 10);
      9:       m = $urandom_range(0, 1) ? 16777215 : 16777216;
      default: m = $urandom_range(0, MAG_LIMIT);
    endcase
    return $urandom_range(0, 1) ? 25'(-m) : 25'(m);
  endfunction

  // pose driver: a new beat is put up only when the bus is free or was just taken
  always @(negedge clk) begin
    if (rst) begin
      pose_valid <= 1'b0;
    end else if (!pose_valid || pose_beat) begin
      if (pend_rd < pend_wr && $urandom_range(0, 99) >= send_idle_pct()) begin
        next_pose = pending_poses[pend_rd];
        pend_rd = pend_rd + 1;
        pos_x      <= next_pose[0];
        pos_y      <= next_pose[1];
        pos_z      <= next_pose[2];
        rot_roll   <= next_pose[3];
        rot_pitch  <= next_pose[4];
        rot_yaw    <= next_pose[5];
        pose_valid <= 1'b1;
      end else begin
        pose_valid <= 1'b0;
      end
    end
  end

  // frame receiver, with one long hold-off so the block backs up onto the pose side
  always @(negedge clk) begin
    if (rst) begin
      frame_ready <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT_POSE) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      frame_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      frame_ready <= 1'b0;
    end else begin
      frame_ready <= ($urandom_range(0, 99) >= recv_stall_pct());
    end
  end

  // monitor: predict on each pose beat, compare each frame beat with the oldest expectation
  always @(posedge clk) begin
    pose_beat = !rst && pose_valid && pose_ready;
    if (pose_beat) begin
      push_frame({rot_yaw, rot_pitch, rot_roll, pos_z, pos_y, pos_x});
      n_accepted = n_accepted + 1;
    end
    if (!rst && frame_valid && frame_ready) begin
      got_beat = '{ch: frame_byte, last: frame_last, clip: clipped};
      if (exp_rd == exp_wr) begin
        $display("%0t: unexpected frame beat byte %h last %b clipped %b",
                 $time, frame_byte, frame_last, clipped);
        n_errors = n_errors + 1;
      end else begin
        want_beat = expected_beats[exp_rd];
        exp_rd = exp_rd + 1;
        if (got_beat.ch !== want_beat.ch) begin
          $display("%0t: frame_byte expected %h actual %h", $time, want_beat.ch, got_beat.ch);
          n_errors = n_errors + 1;
        end
        if (got_beat.last !== want_beat.last) begin
          $display("%0t: frame_last expected %b actual %b",
                   $time, want_beat.last, got_beat.last);
          n_errors = n_errors + 1;
        end
        if (got_beat.clip !== want_beat.clip) begin
          $display("%0t: clipped expected %b actual %b", $time, want_beat.clip, got_beat.clip);
          n_errors = n_errors + 1;
        end
      end
    end
  end

  initial begin
    // extremes, saturation on either side and in single lanes, sign corners
    add_pose(0, 0, 0, 0, 0, 0);
    add_pose(MAG_LIMIT, MAG_LIMIT, MAG_LIMIT, MAG_LIMIT, MAG_LIMIT, MAG_LIMIT);
    add_pose(-MAG_LIMIT, -MAG_LIMIT, -MAG_LIMIT, -MAG_LIMIT, -MAG_LIMIT, -MAG_LIMIT);
    add_pose(10000000, -10000000, 0, 1, -1, 9999);
    add_pose(16777215, -16777216, 0, 0, 0, 0);
    add_pose(1, -1, 10000, -10000, 99999, -99999);
    add_pose(1234567, -7654321, 5000000, -5000001, 42, -42);
    add_pose(-1, -1, -1, -1, -1, -1);
    add_pose(0, 0, 0, 0, 0, 10000000);
    add_pose(-10000000, 0, 0, 0, 0, 0);
    add_pose(MAG_LIMIT - 1, -(MAG_LIMIT - 1), 10000001, 0, 0, 0);
    add_pose('h0AAAAAA, 'h1555555, 'h0555555, 'h1AAAAAA, 'h0FFFFFF, 'h1000000);
    add_pose(9999, 10001, -9999, -10001, 999, -1000);
    add_pose(16777216, 16777215, -MAG_LIMIT, MAG_LIMIT, 0, -1);
    for (int n = 0; n < RANDOM_POSES; n++) begin
      pending_poses[pend_wr] = {rand_value(), rand_value(), rand_value(),
                                rand_value(), rand_value(), rand_value()};
      pend_wr = pend_wr + 1;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (pend_rd < pend_wr || pose_valid || exp_rd < exp_wr) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && exp_rd == exp_wr) begin
      $display("pose_ascii_frame_formatter_unit verification clean");
    end else begin
      $display("pose_ascii_frame_formatter_unit verification failed");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("pose_ascii_frame_formatter_unit verification failed");
    $finish;
  end

endmodule
